FILE: rtl/core/lrs_pkg.sv
package lrs_pkg;

  localparam int unsigned ROW_W       = 64;
  localparam int unsigned COL_W       = 7;
  localparam int unsigned MAX_COLUMNS = 64;
  localparam int unsigned RES_DEPTH   = 4;

  localparam logic [COL_W-1:0] COLS_RESET = COL_W'(64);

  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef logic [ROW_W-1:0] row_t;
  typedef logic [COL_W-1:0] cols_t;

  typedef struct packed {
    row_t next_row_cells;
    logic generation_end;
  } result_t;

  // Bit j set when column j is in use; counts above max_cols act as max_cols.
  function automatic row_t col_mask(input cols_t cols, input int unsigned max_cols);
    int unsigned eff;
    row_t        m;
    eff = (int'(cols) > max_cols) ? max_cols : int'(cols);
    for (int j = 0; j < ROW_W; j++) begin
      m[j] = (j < eff);
    end
    return m;
  endfunction

endpackage

FILE: rtl/core/lrs_row_if.sv
interface lrs_row_if;
  logic          valid;
  logic          ready;
  lrs_pkg::row_t row_cells;
  logic          first_row;
  logic          last_row;

  modport source (output valid, row_cells, first_row, last_row, input ready);
  modport sink   (input valid, row_cells, first_row, last_row, output ready);
endinterface

FILE: rtl/core/lrs_res_if.sv
interface lrs_res_if;
  logic          valid;
  logic          ready;
  lrs_pkg::row_t next_row_cells;
  logic          generation_end;

  modport source (output valid, next_row_cells, generation_end, input ready);
  modport sink   (input valid, next_row_cells, generation_end, output ready);
endinterface

FILE: rtl/core/lrs_lane.sv
module lrs_lane (
  input  logic [2:0] above_i,
  input  logic [2:0] mid_i,
  input  logic [2:0] below_i,
  output logic       alive_o
);
  import lrs_pkg::*;

  logic [7:0] nbr;
  logic [3:0] cnt;

  assign nbr     = {above_i, mid_i[2], mid_i[0], below_i};
  assign cnt     = 4'($countones(nbr));
  assign alive_o = (cnt == BIRTH_COUNT) || (mid_i[1] && (cnt == SURVIVE_COUNT));
endmodule

FILE: rtl/core/lrs_row_eval.sv
module lrs_row_eval (
  input  lrs_pkg::row_t above_i,
  input  lrs_pkg::row_t mid_i,
  input  lrs_pkg::row_t below_i,
  input  lrs_pkg::row_t mask_i,
  output lrs_pkg::row_t next_o
);
  import lrs_pkg::*;

  logic [ROW_W+1:0] above_x;
  logic [ROW_W+1:0] mid_x;
  logic [ROW_W+1:0] below_x;
  row_t             lane_bits;

  // dead border column on each side
  assign above_x = {1'b0, above_i & mask_i, 1'b0};
  assign mid_x   = {1'b0, mid_i & mask_i, 1'b0};
  assign below_x = {1'b0, below_i & mask_i, 1'b0};

  for (genvar j = 0; j < ROW_W; j++) begin : g_lane
    lrs_lane u_lane (
      .above_i (above_x[j+2:j]),
      .mid_i   (mid_x[j+2:j]),
      .below_i (below_x[j+2:j]),
      .alive_o (lane_bits[j])
    );
  end

  assign next_o = lane_bits & mask_i;
endmodule

FILE: rtl/core/lrs_res_fifo.sv
module lrs_res_fifo #(
  parameter int unsigned DEPTH = lrs_pkg::RES_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push0_i,
  input  lrs_pkg::result_t data0_i,
  input  logic             push1_i,
  input  lrs_pkg::result_t data1_i,
  output logic             room2_o,
  lrs_res_if.source        res_o
);
  import lrs_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  result_t          mem_q [DEPTH];
  logic [PTR_W-1:0] wp_q, wp_d, rp_q, rp_d, wp_nx;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;
  logic [1:0]       n_push;
  result_t          w0, w1;

  function automatic logic [PTR_W-1:0] inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // first pushed entry takes slot wp, second slot wp+1
  assign w0     = push0_i ? data0_i : data1_i;
  assign w1     = data1_i;
  assign n_push = {1'b0, push0_i} + {1'b0, push1_i};
  assign wp_nx  = inc(wp_q);
  assign pop    = res_o.valid && res_o.ready;

  assign room2_o              = (int'(cnt_q) + 2) <= DEPTH;
  assign res_o.valid          = (cnt_q != '0);
  assign res_o.next_row_cells = mem_q[rp_q].next_row_cells;
  assign res_o.generation_end = mem_q[rp_q].generation_end;

  always_comb begin
    wp_d = wp_q;
    if (n_push == 2'd1) begin
      wp_d = wp_nx;
    end else if (n_push == 2'd2) begin
      wp_d = inc(wp_nx);
    end
    rp_d  = pop ? inc(rp_q) : rp_q;
    cnt_d = cnt_q + CNT_W'(n_push) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      if ((n_push != 2'd0) && (wp_q == PTR_W'(i))) begin
        mem_q[i] <= w0;
      end else if ((n_push == 2'd2) && (wp_nx == PTR_W'(i))) begin
        mem_q[i] <= w1;
      end
    end
  end
endmodule

FILE: rtl/core/life_automaton_row_step.sv
// Row stepper for Conway's Life (B3/S23) on a bounded grid with dead edges.
// row_i takes one row of the current generation per request, top to bottom,
// with first_row / last_row flags; res_o gives next-generation rows in order.
// A row below a pending row yields that row's successor; a bottom row also
// yields its own successor, flagged generation_end, so a request gives 0, 1
// or 2 results. cfg_we_i / cfg_data_i set columns_in_use (reset 64); columns
// at or beyond it read as dead and come out zero. Write it only while idle.
// The results of a row are registered into the output queue when the row is
// accepted and leave it in order on res_o, first result first.
// Throughput: one row per cycle while ready; both 64-lane row evaluators and
// the merge settle in the accept cycle and results drop into a 4-entry output
// queue that drains one result per cycle. row_i.ready stays high while the
// queue has room for two results, so a stalled receiver backs up into row_i
// after the queue fills. Reset empties the queue and drops any pending row.
module life_automaton_row_step #(
  parameter int unsigned RES_DEPTH   = lrs_pkg::RES_DEPTH,
  parameter int unsigned MAX_COLUMNS = lrs_pkg::MAX_COLUMNS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  lrs_pkg::cols_t cfg_data_i,
  lrs_row_if.sink       row_i,
  lrs_res_if.source     res_o
);
  import lrs_pkg::*;

  row_t    mask_q;
  row_t    above_q, above_d;
  row_t    mid_q, mid_d;
  logic    pend_q, pend_d;
  row_t    row_m, above_b, next_a, next_b;
  logic    acc, start, room2;
  result_t res_a, res_b;

  assign acc         = row_i.valid && row_i.ready;
  assign row_i.ready = room2;
  assign row_m       = row_i.row_cells & mask_q;
  assign start       = row_i.first_row || !pend_q;
  assign above_b     = start ? '0 : mid_q;

  lrs_row_eval u_eval_a (
    .above_i (above_q),
    .mid_i   (mid_q),
    .below_i (row_m),
    .mask_i  (mask_q),
    .next_o  (next_a)
  );

  lrs_row_eval u_eval_b (
    .above_i (above_b),
    .mid_i   (row_m),
    .below_i ('0),
    .mask_i  (mask_q),
    .next_o  (next_b)
  );

  assign res_a = '{next_row_cells: next_a, generation_end: 1'b0};
  assign res_b = '{next_row_cells: next_b, generation_end: 1'b1};

  lrs_res_fifo #(
    .DEPTH (RES_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push0_i (acc && !start),
    .data0_i (res_a),
    .push1_i (acc && row_i.last_row),
    .data1_i (res_b),
    .room2_o (room2),
    .res_o   (res_o)
  );

  always_comb begin
    above_d = above_q;
    mid_d   = mid_q;
    pend_d  = pend_q;
    if (acc) begin
      if (row_i.last_row) begin
        above_d = '0;
        mid_d   = '0;
        pend_d  = 1'b0;
      end else begin
        above_d = above_b;
        mid_d   = row_m;
        pend_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= col_mask(COLS_RESET, MAX_COLUMNS);
      above_q <= '0;
      mid_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mask_q <= col_mask(cfg_data_i, MAX_COLUMNS);
      end
      above_q <= above_d;
      mid_q   <= mid_d;
      pend_q  <= pend_d;
    end
  end
endmodule
